@@ rtl/iva_pkg.sv @@
// shared types and constants for the interval overlap accumulator
// used by iva_front, iva_queue, iva_back and interval_overlap_accumulator
package iva_pkg;

   // reference table size and derived index widths
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int POS_W = 30;
   localparam int SUM_W = 36;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // request codes on the input channel
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_RESTART = 2'd1;
   localparam logic [1:0] REQ_PLACE   = 2'd2;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation carried through the queue
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_RESTART,
      OP_PLACE
   } op_type;

   // one queued word: load carries left/right, place carries start/end
   typedef struct packed {
      op_type           op;
      logic [POS_W-1:0] a;
      logic [POS_W-1:0] b;
      logic             last;
   } entry_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

@@ rtl/iva_front.sv @@
// front end: accepts request words, drops no-ops, places segments
// depends on iva_pkg; feeds iva_queue
module iva_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic [iva_pkg::POS_W-1:0] req_ref_left,
   input  logic [iva_pkg::POS_W-1:0] req_ref_right,
   input  logic [iva_pkg::POS_W-1:0] req_gap_before,
   input  logic [iva_pkg::POS_W-1:0] req_segment_length,
   input  logic                     req_is_last,
   input  logic                     q_full,
   output logic                     q_push,
   output iva_pkg::entry_type       q_entry
);

   logic [iva_pkg::POS_W-1:0] prev_end_ff;
   logic [iva_pkg::POS_W-1:0] prev_end_in;
   logic [iva_pkg::POS_W+1:0] start_sum;
   logic [iva_pkg::POS_W+1:0] end_sum;
   logic [iva_pkg::POS_W-1:0] seg_start;
   logic [iva_pkg::POS_W-1:0] seg_end;
   logic                      accept;

   // handshake: hold off while the queue is full
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // placement: end is saturated directly from the full sum
   always_comb begin
      start_sum = {2'b00, prev_end_ff} + {2'b00, req_gap_before} + (iva_pkg::POS_W + 2)'(1);
      end_sum   = {2'b00, prev_end_ff} + {2'b00, req_gap_before}
                + {2'b00, req_segment_length} + (iva_pkg::POS_W + 2)'(1);
      seg_start = (start_sum > {2'b00, iva_pkg::POS_MAX}) ? iva_pkg::POS_MAX
                : start_sum[iva_pkg::POS_W-1:0];
      seg_end   = (end_sum > {2'b00, iva_pkg::POS_MAX}) ? iva_pkg::POS_MAX
                : end_sum[iva_pkg::POS_W-1:0];
   end

   // classify the word and build the queue entry
   always_comb begin
      q_push       = 1'b0;
      q_entry.op   = iva_pkg::OP_LOAD;
      q_entry.a    = req_ref_left;
      q_entry.b    = req_ref_right;
      q_entry.last = req_is_last;
      prev_end_in  = prev_end_ff;
      case (req_type)
         iva_pkg::REQ_LOAD: begin
            q_push = accept;
         end
         iva_pkg::REQ_RESTART: begin
            q_push     = accept;
            q_entry.op = iva_pkg::OP_RESTART;
            if (accept) begin
               prev_end_in = '0;
            end
         end
         iva_pkg::REQ_PLACE: begin
            q_push     = accept;
            q_entry.op = iva_pkg::OP_PLACE;
            q_entry.a  = seg_start;
            q_entry.b  = seg_end;
            if (accept) begin
               prev_end_in = seg_end;
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_end_ff <= '0;
      end else begin
         prev_end_ff <= prev_end_in;
      end
   end

endmodule

@@ rtl/iva_queue.sv @@
// short first-in first-out queue between the front and back ends
// depends on iva_pkg for the entry type and depth
module iva_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iva_pkg::entry_type push_entry,
   output logic               full,
   output logic               q_valid,
   input  logic               pop,
   output iva_pkg::entry_type pop_entry
);

   iva_pkg::entry_type             entries_ff [iva_pkg::QUEUE_DEPTH];
   logic [iva_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [iva_pkg::QPTR_W-1:0]     wr_ptr_in;
   logic [iva_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [iva_pkg::QPTR_W-1:0]     rd_ptr_in;
   logic [iva_pkg::QCNT_W-1:0]     count_ff;
   logic [iva_pkg::QCNT_W-1:0]     count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full      = (count_ff == iva_pkg::QCNT_W'(iva_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && q_valid;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == iva_pkg::QPTR_W'(iva_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + iva_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == iva_pkg::QPTR_W'(iva_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + iva_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + iva_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - iva_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/iva_back.sv @@
// back end: reference table memory, overlap scan and result register
// depends on iva_pkg; drains iva_queue
module iva_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  iva_pkg::entry_type        q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [iva_pkg::POS_W-1:0] rsp_seg_start,
   output logic [iva_pkg::POS_W-1:0] rsp_seg_end,
   output logic [iva_pkg::SUM_W-1:0] rsp_seg_overlap,
   output logic [iva_pkg::SUM_W-1:0] rsp_running_total,
   output logic                      rsp_last_of_pass,
   output logic                      rsp_table_full
);

   // reference table
   logic [iva_pkg::POS_W-1:0] left_mem  [iva_pkg::TABLE_DEPTH];
   logic [iva_pkg::POS_W-1:0] right_mem [iva_pkg::TABLE_DEPTH];
   logic [iva_pkg::POS_W-1:0] rd_left_ff;
   logic [iva_pkg::POS_W-1:0] rd_right_ff;

   iva_pkg::state_type        state_ff;
   iva_pkg::state_type        state_in;

   logic [iva_pkg::CNT_W-1:0] count_ff;
   logic [iva_pkg::CNT_W-1:0] count_in;
   logic                      full_flag_ff;
   logic                      full_flag_in;
   logic [iva_pkg::SUM_W-1:0] total_ff;
   logic [iva_pkg::SUM_W-1:0] total_in;

   // scan state
   logic [iva_pkg::POS_W-1:0] start_ff;
   logic [iva_pkg::POS_W-1:0] start_in;
   logic [iva_pkg::POS_W-1:0] end_ff;
   logic [iva_pkg::POS_W-1:0] end_in;
   logic                      last_ff;
   logic                      last_in;
   logic [iva_pkg::CNT_W-1:0] rd_idx_ff;
   logic [iva_pkg::CNT_W-1:0] rd_idx_in;
   logic                      rd_vld_ff;
   logic                      rd_vld_in;
   logic                      stop_ff;
   logic                      stop_in;
   logic [iva_pkg::POS_W:0]   term_ff;
   logic [iva_pkg::POS_W:0]   term_in;
   logic                      term_vld_ff;
   logic                      term_vld_in;
   logic [iva_pkg::SUM_W-1:0] acc_ff;
   logic [iva_pkg::SUM_W-1:0] acc_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   // sequencer controls
   logic                      mem_we;
   logic                      issue;
   logic                      scan_done;
   logic                      out_load;
   logic                      start_scan;

   // per-entry overlap terms
   logic                      brk;
   logic [iva_pkg::POS_W-1:0] hi;
   logic [iva_pkg::POS_W-1:0] lo;
   logic [iva_pkg::SUM_W:0]   acc_sum;
   logic [iva_pkg::SUM_W:0]   total_sum;

   // control outputs of the sequencer
   always_comb begin
      q_pop      = (state_ff == iva_pkg::ST_IDLE) && q_valid;
      start_scan = q_pop && (q_entry.op == iva_pkg::OP_PLACE);
      mem_we     = q_pop && (q_entry.op == iva_pkg::OP_LOAD)
                && (count_ff < iva_pkg::CNT_W'(iva_pkg::TABLE_DEPTH));
      issue      = (state_ff == iva_pkg::ST_SCAN) && !stop_ff && (rd_idx_ff < count_ff);
      scan_done  = (state_ff == iva_pkg::ST_SCAN) && !issue && !rd_vld_ff && !term_vld_ff;
      out_load   = (state_ff == iva_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iva_pkg::ST_IDLE: begin
            if (start_scan) begin
               state_in = iva_pkg::ST_SCAN;
            end
         end
         iva_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = iva_pkg::ST_DONE;
            end
         end
         iva_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = iva_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iva_pkg::ST_IDLE;
         end
      endcase
   end

   // overlap of one table entry with the segment
   always_comb begin
      brk     = (rd_left_ff > end_ff);
      hi      = (rd_right_ff < end_ff) ? rd_right_ff : end_ff;
      lo      = (rd_left_ff > start_ff) ? rd_left_ff : start_ff;
      term_in = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + (iva_pkg::POS_W + 1)'(1)) : '0;
   end

   // saturating sums
   always_comb begin
      acc_sum   = {1'b0, acc_ff} + (iva_pkg::SUM_W + 1)'(term_ff);
      total_sum = {1'b0, total_ff} + {1'b0, acc_ff};
   end

   // next values of the datapath and bookkeeping registers
   always_comb begin
      count_in     = count_ff;
      full_flag_in = full_flag_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = issue;
      stop_in      = stop_ff;
      term_vld_in  = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // table load and restart
      if (q_pop && (q_entry.op == iva_pkg::OP_LOAD)) begin
         if (mem_we) begin
            count_in = count_ff + iva_pkg::CNT_W'(1);
         end else begin
            full_flag_in = 1'b1;
         end
      end
      if (q_pop && (q_entry.op == iva_pkg::OP_RESTART)) begin
         total_in = '0;
      end

      // start of a scan
      if (start_scan) begin
         start_in  = q_entry.a;
         end_in    = q_entry.b;
         last_in   = q_entry.last;
         rd_idx_in = '0;
         stop_in   = 1'b0;
         acc_in    = '0;
      end

      // read issue
      if (issue) begin
         rd_idx_in = rd_idx_ff + iva_pkg::CNT_W'(1);
      end

      // compare stage: stop at the first entry past the segment end
      if (rd_vld_ff && !stop_ff) begin
         if (brk) begin
            stop_in = 1'b1;
         end else begin
            term_vld_in = 1'b1;
         end
      end

      // accumulate stage
      if (term_vld_ff) begin
         acc_in = (acc_sum > {1'b0, iva_pkg::SUM_MAX}) ? iva_pkg::SUM_MAX
                : acc_sum[iva_pkg::SUM_W-1:0];
      end

      // result hand-off
      if (out_load) begin
         rsp_valid_in = 1'b1;
         total_in     = (total_sum > {1'b0, iva_pkg::SUM_MAX}) ? iva_pkg::SUM_MAX
                      : total_sum[iva_pkg::SUM_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iva_pkg::ST_IDLE;
         count_ff     <= '0;
         full_flag_ff <= 1'b0;
         total_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         stop_ff      <= 1'b0;
         term_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         full_flag_ff <= full_flag_in;
         total_ff     <= total_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         stop_ff      <= stop_in;
         term_vld_ff  <= term_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_mem[count_ff[iva_pkg::IDX_W-1:0]]  <= q_entry.a;
         right_mem[count_ff[iva_pkg::IDX_W-1:0]] <= q_entry.b;
      end
      if (issue) begin
         rd_left_ff  <= left_mem[rd_idx_ff[iva_pkg::IDX_W-1:0]];
         rd_right_ff <= right_mem[rd_idx_ff[iva_pkg::IDX_W-1:0]];
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_seg_start     <= start_ff;
         rsp_seg_end       <= end_ff;
         rsp_seg_overlap   <= acc_ff;
         rsp_running_total <= total_in;
         rsp_last_of_pass  <= last_ff;
         rsp_table_full    <= full_flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/interval_overlap_accumulator.sv @@
// Interval overlap accumulator. Request words on the req_ channel (valid/stall)
// either load a reference interval into the table (code 0), restart the pass
// (code 1, clears position and running total, keeps the table) or place a
// segment (code 2). Code 3 is taken and ignored. Only placements return a word
// on the rsp_ channel: start, end, overlap of this segment, running total,
// the last-of-pass echo and the sticky table-full flag.
// A front end places segments and classifies words; a two-entry queue links
// it to a back end that owns the table memory and runs the overlap scan.
// The back end handles loads and restarts without leaving its idle state. A
// placement's scan reads the table entries in order, stopping at the first
// left edge past the segment end, and its result is registered once the
// scan has drained. The single read port of the table memory delivers one
// entry per cycle during a scan; n, the entries summed, is at most 1024.
// The back end can take its next word in the cycle the result appears, and a
// word is registered in the queue before the back end takes it. The front
// keeps accepting words until the queue fills. When rsp_stall is high the
// result holds, and the back end waits with the next finished result until
// the register frees. Reset (synchronous, active high) empties the table,
// clears the position, the total and the table-full flag; no clearing pass.
// depends on iva_pkg, iva_front, iva_queue, iva_back
module interval_overlap_accumulator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [iva_pkg::POS_W-1:0] req_ref_left,
   input  logic [iva_pkg::POS_W-1:0] req_ref_right,
   input  logic [iva_pkg::POS_W-1:0] req_gap_before,
   input  logic [iva_pkg::POS_W-1:0] req_segment_length,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [iva_pkg::POS_W-1:0] rsp_seg_start,
   output logic [iva_pkg::POS_W-1:0] rsp_seg_end,
   output logic [iva_pkg::SUM_W-1:0] rsp_seg_overlap,
   output logic [iva_pkg::SUM_W-1:0] rsp_running_total,
   output logic                      rsp_last_of_pass,
   output logic                      rsp_table_full
);

   logic               q_full;
   logic               q_push;
   logic               q_valid;
   logic               q_pop;
   iva_pkg::entry_type push_entry;
   iva_pkg::entry_type pop_entry;

   // front end
   iva_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_ref_left       (req_ref_left),
      .req_ref_right      (req_ref_right),
      .req_gap_before     (req_gap_before),
      .req_segment_length (req_segment_length),
      .req_is_last        (req_is_last),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   // queue between front and back
   iva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_valid    (q_valid),
      .pop        (q_pop),
      .pop_entry  (pop_entry)
   );

   // back end
   iva_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (pop_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_seg_start     (rsp_seg_start),
      .rsp_seg_end       (rsp_seg_end),
      .rsp_seg_overlap   (rsp_seg_overlap),
      .rsp_running_total (rsp_running_total),
      .rsp_last_of_pass  (rsp_last_of_pass),
      .rsp_table_full    (rsp_table_full)
   );

endmodule

@@ sim/interval_overlap_accumulator_tb.sv @@
// testbench for interval_overlap_accumulator: drives request words with random idling,
// predicts every placement word and checks each result word field by field
// depends on iva_pkg and the interval_overlap_accumulator rtl
module interval_overlap_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // request code the block takes and drops
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   localparam int RANDOM_WORDS = 500;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int FULL_COVER   = 80;

   typedef struct packed {
      logic [1:0]                kind;
      logic [iva_pkg::POS_W-1:0] left_edge;
      logic [iva_pkg::POS_W-1:0] right_edge;
      logic [iva_pkg::POS_W-1:0] gap;
      logic [iva_pkg::POS_W-1:0] seg_len;
      logic                      last;
   } request_word_type;

   typedef struct packed {
      logic [iva_pkg::POS_W-1:0] start_pos;
      logic [iva_pkg::POS_W-1:0] end_pos;
      logic [iva_pkg::SUM_W-1:0] overlap;
      logic [iva_pkg::SUM_W-1:0] total;
      logic                      last;
      logic                      dropped;
   } placement_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type = REQ_IGNORED;
   logic [iva_pkg::POS_W-1:0] req_ref_left = '0;
   logic [iva_pkg::POS_W-1:0] req_ref_right = '0;
   logic [iva_pkg::POS_W-1:0] req_gap_before = '0;
   logic [iva_pkg::POS_W-1:0] req_segment_length = '0;
   logic                      req_is_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [iva_pkg::POS_W-1:0] rsp_seg_start;
   logic [iva_pkg::POS_W-1:0] rsp_seg_end;
   logic [iva_pkg::SUM_W-1:0] rsp_seg_overlap;
   logic [iva_pkg::SUM_W-1:0] rsp_running_total;
   logic                      rsp_last_of_pass;
   logic                      rsp_table_full;

   // predicted block state
   logic [iva_pkg::POS_W-1:0] table_left [iva_pkg::TABLE_DEPTH];
   logic [iva_pkg::POS_W-1:0] table_right [iva_pkg::TABLE_DEPTH];
   int                        table_count = 0;
   longint unsigned           last_end = 0;
   longint unsigned           pass_total = 0;
   bit                        load_dropped = 1'b0;
   placement_type             pending_placements[$];

   int                        mismatch_count = 0;
   int                        cycle_count = 0;
   bit                        idle_on = 1'b1;
   int                        hold_requests = 0;
   int                        hold_served = 0;
   int                        hold_left = 0;
   int                        stall_left = 0;
   logic [iva_pkg::POS_W-1:0] load_cursor = '0;

   interval_overlap_accumulator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_ref_left       (req_ref_left),
      .req_ref_right      (req_ref_right),
      .req_gap_before     (req_gap_before),
      .req_segment_length (req_segment_length),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_seg_start      (rsp_seg_start),
      .rsp_seg_end        (rsp_seg_end),
      .rsp_seg_overlap    (rsp_seg_overlap),
      .rsp_running_total  (rsp_running_total),
      .rsp_last_of_pass   (rsp_last_of_pass),
      .rsp_table_full     (rsp_table_full)
   );

   initial forever #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: run limit reached", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [iva_pkg::POS_W-1:0] rand_pos();
      return iva_pkg::POS_W'($urandom());
   endfunction

   // mostly short spans, sometimes zero, huge or near the top of the axis
   function automatic logic [iva_pkg::POS_W-1:0] random_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 80) return iva_pkg::POS_W'($urandom_range(0, 2000));
      if (r < 90) return iva_pkg::POS_W'($urandom_range(2000, 40000));
      if (r < 95) return iva_pkg::POS_MAX - iva_pkg::POS_W'($urandom_range(0, 50));
      return rand_pos();
   endfunction

   function automatic request_word_type random_word(input logic [1:0] kind);
      request_word_type w;
      w.kind = kind;
      w.left_edge = rand_pos();
      w.right_edge = rand_pos();
      w.gap = rand_pos();
      w.seg_len = rand_pos();
      w.last = 1'($urandom());
      return w;
   endfunction

   // table update, restart, or placement with its overlap scan
   function automatic void absorb_request(input request_word_type w);
      longint unsigned s, e, lo, hi, sum;
      placement_type p;
      case (w.kind)
         iva_pkg::REQ_LOAD: begin
            if (table_count < iva_pkg::TABLE_DEPTH) begin
               table_left[table_count] = w.left_edge;
               table_right[table_count] = w.right_edge;
               table_count++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         iva_pkg::REQ_RESTART: begin
            last_end = 0;
            pass_total = 0;
         end
         iva_pkg::REQ_PLACE: begin
            s = last_end + w.gap + 1;
            if (s > iva_pkg::POS_MAX) s = iva_pkg::POS_MAX;
            e = s + w.seg_len;
            if (e > iva_pkg::POS_MAX) e = iva_pkg::POS_MAX;
            last_end = e;
            sum = 0;
            // scan from the first entry, stop at the first left edge past the end
            for (int j = 0; j < table_count; j++) begin
               if (table_left[j] > e) break;
               hi = (table_right[j] < e) ? table_right[j] : e;
               lo = (table_left[j] > s) ? table_left[j] : s;
               if (hi >= lo) sum += hi - lo + 1;
            end
            if (sum > iva_pkg::SUM_MAX) sum = iva_pkg::SUM_MAX;
            pass_total += sum;
            if (pass_total > iva_pkg::SUM_MAX) pass_total = iva_pkg::SUM_MAX;
            p.start_pos = iva_pkg::POS_W'(s);
            p.end_pos = iva_pkg::POS_W'(e);
            p.overlap = iva_pkg::SUM_W'(sum);
            p.total = iva_pkg::SUM_W'(pass_total);
            p.last = w.last;
            p.dropped = load_dropped;
            pending_placements.push_back(p);
         end
         default: ;
      endcase
   endfunction

   // offer one word after a drawn pause, predict once it is taken
   task automatic send_word(input request_word_type w);
      int pause;
      pause = idle_on ? $urandom_range(0, 12) : 0;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= w.kind;
      req_ref_left <= w.left_edge;
      req_ref_right <= w.right_edge;
      req_gap_before <= w.gap;
      req_segment_length <= w.seg_len;
      req_is_last <= w.last;
      do @(posedge clock); while (req_stall);
      absorb_request(w);
   endtask

   task automatic send_load(input logic [iva_pkg::POS_W-1:0] l,
                            input logic [iva_pkg::POS_W-1:0] r);
      request_word_type w;
      w = random_word(iva_pkg::REQ_LOAD);
      w.left_edge = l;
      w.right_edge = r;
      send_word(w);
   endtask

   task automatic send_place(input logic [iva_pkg::POS_W-1:0] g,
                             input logic [iva_pkg::POS_W-1:0] n,
                             input logic last);
      request_word_type w;
      w = random_word(iva_pkg::REQ_PLACE);
      w.gap = g;
      w.seg_len = n;
      w.last = last;
      send_word(w);
   endtask

   // mostly ascending left edges near the region that segments cover
   task automatic load_next_ref();
      logic [iva_pkg::POS_W-1:0] right;
      int r;
      load_cursor += iva_pkg::POS_W'($urandom_range(0, 600));
      if (load_cursor > 40000) load_cursor = iva_pkg::POS_W'($urandom_range(0, 2000));
      r = $urandom_range(0, 19);
      if (r == 0) right = rand_pos();
      else if (r < 3 && load_cursor != 0)
         right = iva_pkg::POS_W'($urandom_range(0, load_cursor - 1));
      else right = load_cursor + iva_pkg::POS_W'($urandom_range(0, 3000));
      send_load(load_cursor, right);
   endtask

   function automatic void check_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // result checking and receiver stalls
   always @(posedge clock) begin : result_monitor
      placement_type want;
      bit took;
      took = !reset && rsp_valid && !rsp_stall;
      if (took) begin
         if (pending_placements.size() == 0) begin
            $display("%0t ns: result word with no placement pending", $time);
            mismatch_count++;
         end else begin
            want = pending_placements.pop_front();
            check_field("seg_start", want.start_pos, rsp_seg_start);
            check_field("seg_end", want.end_pos, rsp_seg_end);
            check_field("seg_overlap", want.overlap, rsp_seg_overlap);
            check_field("running_total", want.total, rsp_running_total);
            check_field("last_of_pass", want.last, rsp_last_of_pass);
            check_field("table_full", want.dropped, rsp_table_full);
         end
      end
      // a long hold-off when the stimulus asks for one
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (took) stall_left = idle_on ? $urandom_range(0, 12) : 0;
         else if (stall_left > 0) stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // empty table, small table by hand, saturation, ignored code
   task automatic test_directed_cases();
      idle_on = 1'b1;
      send_place('0, '0, 1'b0);
      send_load(30'd0, 30'd3);
      send_load(30'd2, 30'd1);
      send_load(30'd5, 30'd5);
      send_load(30'd8, 30'd20);
      send_word(random_word(iva_pkg::REQ_RESTART));
      send_place('0, 30'd9, 1'b0);
      send_place('0, '0, 1'b1);
      send_place(iva_pkg::POS_MAX, '0, 1'b0);
      send_place('0, iva_pkg::POS_MAX, 1'b1);
      send_word(random_word(iva_pkg::REQ_RESTART));
      send_place('0, iva_pkg::POS_MAX, 1'b1);
      send_word('1);
      send_word(random_word(REQ_IGNORED));
      send_place(30'd3, 30'd2, 1'b0);
      send_word(random_word(iva_pkg::REQ_RESTART));
      send_place(30'd1, 30'd4, 1'b1);
   endtask

   // passes of placements with some loads, ignored words and broken passes
   task automatic test_random_passes();
      int sent, n, pick;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) != 0) begin
            send_word(random_word(iva_pkg::REQ_RESTART));
            sent++;
         end
         n = $urandom_range(1, 12);
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_place(random_span(), random_span(),
                          (k == n - 1) || ($urandom_range(0, 9) == 0));
               sent++;
            end else if (pick < 80) begin
               load_next_ref();
               sent++;
            end else if (pick < 85) begin
               send_word(random_word(REQ_IGNORED));
            end else if (pick < 95) begin
               send_place(rand_pos(), rand_pos(), 1'($urandom()));
               sent++;
            end else begin
               send_word(random_word(iva_pkg::REQ_RESTART));
               sent++;
            end
         end
      end
   endtask

   // receiver holds off while words keep coming, so the block backs up
   task automatic test_result_backpressure();
      idle_on = 1'b0;
      hold_requests++;
      send_word(random_word(iva_pkg::REQ_RESTART));
      for (int k = 0; k < 24; k++) begin
         if (k % 6 == 5) load_next_ref();
         else send_place(random_span(), random_span(), k == 23);
      end
      idle_on = 1'b1;
   endtask

   // fill the table, overflow it, saturate the overlap sums
   task automatic test_table_overflow();
      idle_on = 1'b0;
      for (int k = 0; k < FULL_COVER; k++) send_load('0, iva_pkg::POS_MAX);
      send_load(iva_pkg::POS_MAX, iva_pkg::POS_MAX);
      idle_on = 1'b1;
      while (table_count < iva_pkg::TABLE_DEPTH) send_load(rand_pos(), rand_pos());
      send_word(random_word(iva_pkg::REQ_RESTART));
      send_place('0, iva_pkg::POS_MAX, 1'b0);
      send_load(rand_pos(), rand_pos());
      send_load(rand_pos(), rand_pos());
      send_place(30'd5, 30'd100, 1'b0);
      send_place(iva_pkg::POS_MAX, '0, 1'b1);
      send_word(random_word(iva_pkg::REQ_RESTART));
      send_place('0, '0, 1'b1);
      send_place(random_span(), random_span(), 1'b0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_passes();
      test_result_backpressure();
      test_table_overflow();
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
